[design/npsu_pkg.sv]
`default_nettype none

package npsu_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 16;
  localparam int AXES = 3;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int IDX_FIELD_W = 10;
  localparam int CNT_W = 11;
  localparam int CMP_W = (CNT_W > IDX_W + 1) ? CNT_W : IDX_W + 1;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W = 2 * COORD_BITS;
  localparam int DIST_W = SQ_W + 2;
  localparam int PT_W = AXES * COORD_BITS;

  localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(1024);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                    valid;
    logic                    first;
    logic                    last;
    logic [IDX_W-1:0]        idx;
    logic [DIST_W-1:0]       acc;
    logic [AXES-1:0][COORD_BITS-1:0] pt;
  } tok_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] best_idx;
  } min_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  function automatic logic [IDX_W-1:0] count_last(input logic [CNT_W-1:0] nc);
    logic [CMP_W-1:0] c;
    c = CMP_W'(nc);
    if (c == '0) begin
      c = CMP_W'(1);
    end
    if (c > CMP_W'(MAX_POINTS)) begin
      c = CMP_W'(MAX_POINTS);
    end
    c = c - CMP_W'(1);
    return c[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

[design/npsu_req_if.sv]
`default_nettype none

interface npsu_req_if
  import npsu_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [IDX_FIELD_W-1:0] node_index;
  coord_t                 coord_x;
  coord_t                 coord_y;
  coord_t                 coord_z;

  modport source (
    output valid, mode, node_index, coord_x, coord_y, coord_z,
    input  ready
  );

  modport sink (
    input  valid, mode, node_index, coord_x, coord_y, coord_z,
    output ready
  );
endinterface

`default_nettype wire

[design/npsu_rsp_if.sv]
`default_nettype none

interface npsu_rsp_if
  import npsu_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [IDX_FIELD_W-1:0] closest_index;

  modport source (
    output valid, closest_index,
    input  ready
  );

  modport sink (
    input  valid, closest_index,
    output ready
  );
endinterface

`default_nettype wire

[design/npsu_cfg_if.sv]
`default_nettype none

interface npsu_cfg_if
  import npsu_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] node_count;

  modport source (
    output valid, node_count,
    input  ready
  );

  modport sink (
    input  valid, node_count,
    output ready
  );
endinterface

`default_nettype wire

[design/npsu_sq_cell.sv]
`default_nettype none

module npsu_sq_cell
  import npsu_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire coord_t q,
  input  wire tok_t   tok_in,
  output tok_t        tok_out
);

  logic signed [DIFF_W-1:0]   diff;
  logic signed [2*DIFF_W-1:0] prod;
  logic [SQ_W-1:0]            sq;
  tok_t                       tok_next;

  always_comb begin
    diff = $signed({tok_in.pt[0][COORD_BITS-1], tok_in.pt[0]})
         - $signed({q[COORD_BITS-1], q});
    prod = diff * diff;
    sq = prod[SQ_W-1:0];
    tok_next = tok_in;
    tok_next.acc = tok_in.acc + DIST_W'(sq);
    // rotate coordinates so the next cell sees its axis at slot 0
    for (int i = 0; i < AXES - 1; i++) begin
      tok_next.pt[i] = tok_in.pt[i+1];
    end
    tok_next.pt[AXES-1] = tok_in.pt[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.first <= tok_next.first;
    tok_out.last  <= tok_next.last;
    tok_out.idx   <= tok_next.idx;
    tok_out.acc   <= tok_next.acc;
    tok_out.pt    <= tok_next.pt;
  end

endmodule

`default_nettype wire

[design/npsu_min_unit.sv]
`default_nettype none

module npsu_min_unit
  import npsu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire tok_t tok,
  output min_stat_t stat
);

  logic [DIST_W-1:0] best_acc;
  logic [IDX_W-1:0]  best_idx;
  logic              done;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tok.valid && tok.last;
    end
    // strict less keeps the lowest index on ties
    if (tok.valid && (tok.first || (tok.acc < best_acc))) begin
      best_acc <= tok.acc;
      best_idx <= tok.idx;
    end
  end

  assign stat.done = done;
  assign stat.best_idx = best_idx;

endmodule

`default_nettype wire

[design/nearest_point_search_unit.sv]
// a query is scanned, drained and its result loaded into the output register
//   before a new request is taken; the single read port of the point memory
//   feeds one point per cycle into the cell chain
// a load item gives no result
// reset (synchronous, active high) sets node_count to 1024 and empties the
//   chain; the point memory is not cleared, there is no clearing pass
`default_nettype none

module nearest_point_search_unit
  import npsu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  npsu_req_if.sink   req,
  npsu_rsp_if.source rsp,
  npsu_cfg_if.sink   cfg
);

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]   node_count;
  logic [IDX_W-1:0]   addr;
  logic [IDX_W-1:0]   cnt_last;
  coord_t [AXES-1:0]  qry;

  logic [PT_W-1:0]    mem [MAX_POINTS];
  logic [PT_W-1:0]    rd_data;
  logic               rd_valid;
  logic               rd_first;
  logic               rd_last;
  logic [IDX_W-1:0]   rd_idx;

  logic               issue;
  logic               load_out;
  logic               accept;
  logic               we;
  logic               slot_ok;

  logic               out_valid;
  logic [IDX_FIELD_W-1:0] out_idx;

  tok_t               chain [AXES+1];
  min_stat_t          mstat;

  assign accept  = req.valid && req.ready;
  assign slot_ok = (CMP_W + IDX_FIELD_W)'(req.node_index) < (CMP_W + IDX_FIELD_W)'(MAX_POINTS);
  assign we      = accept && (req.mode == MODE_LOAD) && slot_ok;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      node_count <= cfg.node_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    issue      = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid && (req.mode == MODE_QUERY)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        issue = 1'b1;
        if (addr == cnt_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mstat.done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && (req.mode == MODE_QUERY)) begin
      addr     <= '0;
      cnt_last <= count_last(node_count);
      qry[0]   <= req.coord_x;
      qry[1]   <= req.coord_y;
      qry[2]   <= req.coord_z;
    end else if (issue) begin
      addr <= addr + IDX_W'(1);
    end
  end

  // point memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[req.node_index[IDX_W-1:0]] <= {req.coord_z, req.coord_y, req.coord_x};
    end
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
    end
    rd_first <= (addr == '0);
    rd_last  <= (addr == cnt_last);
    rd_idx   <= addr;
  end

  always_comb begin
    chain[0].valid = rd_valid;
    chain[0].first = rd_first;
    chain[0].last  = rd_last;
    chain[0].idx   = rd_idx;
    chain[0].acc   = '0;
    chain[0].pt    = rd_data;
  end

  for (genvar k = 0; k < AXES; k++) begin : g_cell
    npsu_sq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .q       (qry[k]),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
  end

  npsu_min_unit u_min (
    .clk  (clk),
    .rst  (rst),
    .tok  (chain[AXES]),
    .stat (mstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      out_idx <= IDX_FIELD_W'(mstat.best_idx);
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.closest_index = out_idx;

  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    mstat.done |-> state == ST_DRAIN)
    else $error("search finished outside drain");

  a_result_after_search: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_RESULT)
    else $error("result shown without a finished search");

  a_no_load_in_scan: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !we)
    else $error("point memory written during a search");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && addr == cnt_last) |=> state == ST_DRAIN)
    else $error("scan did not stop at the last point");

endmodule

`default_nettype wire
